/* rtl/lppe_pkg.sv */
// Package for the lidar point polar expander: word types, constants, tables.
// No dependencies.
`timescale 1ns / 1ps
package lppe_pkg;

  localparam int MaxChannels = 128;
  localparam int ChanIdxW    = $clog2(MaxChannels);
  localparam int ChanCntW    = $clog2(MaxChannels + 1);
  localparam int CordicSteps = 24;
  localparam int StepW       = 6;
  localparam int QDepth      = 2;
  localparam int QPtrW       = 1;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_POINT  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        raw_intensity;
    logic [19:0]        channel_points;
    logic signed [15:0] channel_elevation;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]        out_intensity;
    logic [31:0]        out_distance;
    logic signed [15:0] out_azimuth;
    logic [6:0]         out_channel;
    logic signed [15:0] out_elevation;
  } out_word_t;

  // point word handed from the front to the back
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        inten;
    logic               ext;
    logic               hit;
    logic [6:0]         chan;
    logic [15:0]        elev;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SQ,
    ST_RUN,
    ST_DONE
  } back_st_t;

  function automatic logic [30:0] atan_turn(input logic [StepW-1:0] i);
    logic [30:0] r;
    begin
      unique case (i)
        6'd0: r = 31'd536870912;   6'd1: r = 31'd316933406;
        6'd2: r = 31'd167458907;   6'd3: r = 31'd85004756;
        6'd4: r = 31'd42667331;    6'd5: r = 31'd21354465;
        6'd6: r = 31'd10679838;    6'd7: r = 31'd5340245;
        6'd8: r = 31'd2670163;     6'd9: r = 31'd1335087;
        6'd10: r = 31'd667544;     6'd11: r = 31'd333772;
        6'd12: r = 31'd166886;     6'd13: r = 31'd83443;
        6'd14: r = 31'd41721;      6'd15: r = 31'd20860;
        6'd16: r = 31'd10430;      6'd17: r = 31'd5215;
        6'd18: r = 31'd2607;       6'd19: r = 31'd1303;
        6'd20: r = 31'd651;        6'd21: r = 31'd325;
        6'd22: r = 31'd162;        6'd23: r = 31'd81;
        default: r = 31'd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/lppe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lppe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/lppe_front.sv */
// Front part: classifies words, keeps the channel table bookkeeping, issues jobs.
// Depends on lppe_pkg and lppe_ram (the table memory).
`timescale 1ns / 1ps
module lppe_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ext_mode,
  input  logic                         in_push,
  output logic                         in_full,
  input  lppe_pkg::in_word_t           in_data,
  output logic                         job_push,
  input  logic                         job_full,
  output lppe_pkg::job_t               job
);
  import lppe_pkg::*;

  logic [ChanCntW-1:0] stored_r, stored_nxt;
  logic [ChanCntW-1:0] next_ch_r, next_ch_nxt;
  logic [ChanCntW-1:0] cur_r, cur_nxt;
  logic [19:0]         used_r, used_nxt;
  logic                acc, is_pt, is_app, wr, hit;
  logic [19:0]         used_inc;
  logic [42:0]         tab_wdata, tab_rdata, byp_data_r, ent;
  logic                byp_r, byp_nxt;

  assign in_full = job_full;
  assign acc     = in_push && !in_full;
  assign is_pt   = in_data.mode == MODE_POINT;
  assign is_app  = in_data.mode == MODE_APPEND;
  assign wr      = acc && is_app && (next_ch_r < ChanCntW'(MaxChannels))
                   && (in_data.channel_points != 20'd0);
  assign hit     = cur_r < stored_r;
  assign used_inc = used_r + 20'd1;
  assign tab_wdata = {in_data.channel_points, in_data.channel_elevation,
                      7'(next_ch_r)};

  // current entry: registered read at the next entry index, newest write forwarded
  lppe_ram #(.Width(43), .Depth(MaxChannels)) u_tab (
    .clk  (clk),
    .we   (wr),
    .waddr(stored_r[ChanIdxW-1:0]),
    .wdata(tab_wdata),
    .raddr(cur_nxt[ChanIdxW-1:0]),
    .rdata(tab_rdata)
  );

  assign byp_nxt = wr && (stored_r[ChanIdxW-1:0] == cur_nxt[ChanIdxW-1:0]);
  assign ent     = byp_r ? byp_data_r : tab_rdata;

  always_ff @(posedge clk) begin
    byp_data_r <= tab_wdata;
  end

  always_comb begin
    stored_nxt  = stored_r;
    next_ch_nxt = next_ch_r;
    cur_nxt     = cur_r;
    used_nxt    = used_r;
    if (acc) begin
      unique case (mode_t'(in_data.mode))
        MODE_CLEAR: begin
          stored_nxt  = '0;
          next_ch_nxt = '0;
          cur_nxt     = '0;
          used_nxt    = '0;
        end
        MODE_APPEND: begin
          if (next_ch_r < ChanCntW'(MaxChannels)) begin
            next_ch_nxt = next_ch_r + 1'b1;
            if (wr) begin
              stored_nxt = stored_r + 1'b1;
            end
          end
        end
        MODE_POINT: begin
          if (hit) begin
            if (used_inc >= ent[42:23]) begin
              cur_nxt  = cur_r + 1'b1;
              used_nxt = '0;
            end else begin
              used_nxt = used_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r  <= '0;
      next_ch_r <= '0;
      cur_r     <= '0;
      used_r    <= '0;
      byp_r     <= 1'b0;
    end else begin
      stored_r  <= stored_nxt;
      next_ch_r <= next_ch_nxt;
      cur_r     <= cur_nxt;
      used_r    <= used_nxt;
      byp_r     <= byp_nxt;
    end
  end

  assign job_push  = acc && is_pt;
  assign job.x     = in_data.coord_x;
  assign job.y     = (in_data.coord_y == 32'sh8000_0000) ? 32'sh7fff_ffff
                                                          : -in_data.coord_y;
  assign job.z     = in_data.coord_z;
  assign job.inten = in_data.raw_intensity;
  assign job.ext   = ext_mode;
  assign job.hit   = hit;
  assign job.chan  = ent[6:0];
  assign job.elev  = ent[22:7];
endmodule

/* rtl/lppe_queue.sv */
// Short job queue between the front and the back parts.
// Depends on lppe_pkg.
`timescale 1ns / 1ps
module lppe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  lppe_pkg::job_t   wdata,
  input  logic             pop,
  output logic             empty,
  output lppe_pkg::job_t   rdata
);
  import lppe_pkg::*;

  job_t              slot_r [QDepth];
  logic [QPtrW-1:0]  wp_r, rp_r;
  logic [QPtrW:0]    cnt_r;
  logic              do_push, do_pop;

  assign full    = cnt_r == (QPtrW+1)'(QDepth);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end
  end
endmodule

/* rtl/lppe_back.sv */
// Back part: in extended mode squares, then CORDIC azimuth and bit-pair square root
// in a shared step loop; holds the result word for the output side.
// Depends on lppe_pkg.
`timescale 1ns / 1ps
module lppe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_empty,
  output logic                          job_pop,
  input  lppe_pkg::job_t                job,
  output logic                          out_empty,
  input  logic                          out_pop,
  output lppe_pkg::out_word_t           out_data
);
  import lppe_pkg::*;

  back_st_t           st_r, st_nxt;
  job_t               job_r;
  logic [StepW-1:0]   step_r;
  logic [1:0]         sq_r;
  logic [65:0]        sum_r;
  logic [65:0]        rem_r;
  logic [33:0]        root_r;
  logic signed [49:0] cx_r, cy_r;
  logic signed [33:0] az_r;
  logic [15:0]        elev_r;
  logic [6:0]         chan_r;
  logic [63:0]        prod;
  logic [31:0]        mag;
  logic               yzero_r;
  out_word_t          res_r;
  logic               full_r;
  logic signed [49:0] dx, dy;
  logic [65:0]        trial, rem_sh;
  logic [33:0]        az_rnd;
  logic signed [17:0] az_q;
  logic [32:0]        root_c;

  assign job_pop   = (st_r == ST_IDLE) && !job_empty;
  assign out_empty = !full_r;
  assign out_data  = res_r;

  always_comb begin
    unique case (sq_r)
      2'd0: mag = job_r.x[31] ? 32'(-job_r.x) : job_r.x;
      2'd1: mag = job_r.y[31] ? 32'(-job_r.y) : job_r.y;
      default: mag = job_r.z[31] ? 32'(-job_r.z) : job_r.z;
    endcase
    prod = mag * mag;
  end

  assign dx     = cy_r >>> step_r;
  assign dy     = cx_r >>> step_r;
  // two bits of the radicand per step, 33 steps over cycles
  assign rem_sh = {rem_r[63:0], sum_r[65:64]};
  assign trial  = {root_r[31:0], 2'b01};
  assign az_rnd = az_r + 34'sd32768;
  assign az_q   = az_rnd[33:16];
  assign root_c = root_r[32:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (!job_empty) st_nxt = ST_LOOK;
      ST_LOOK: st_nxt = job_r.ext ? ST_SQ : ST_DONE;
      ST_SQ:   if (sq_r == 2'd2) st_nxt = ST_RUN;
      ST_RUN:  if (step_r == StepW'(32)) st_nxt = ST_DONE;
      ST_DONE: if (!full_r || out_pop) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && (!full_r || out_pop)) begin
        full_r <= 1'b1;
      end else if (out_pop) begin
        full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        job_r  <= job;
        sq_r   <= '0;
        sum_r  <= '0;
        step_r <= '0;
      end
      ST_LOOK: begin
        chan_r  <= job_r.hit ? job_r.chan : 7'd0;
        elev_r  <= job_r.hit ? job_r.elev : 16'd0;
        yzero_r <= job_r.y == 32'sd0;
        if (job_r.x[31]) begin
          if (!job_r.y[31]) begin
            cx_r <= 50'(job_r.y) <<< 16;
            cy_r <= -(50'(job_r.x) <<< 16);
            az_r <= 34'sd1073741824;
          end else begin
            cx_r <= -(50'(job_r.y) <<< 16);
            cy_r <= 50'(job_r.x) <<< 16;
            az_r <= -34'sd1073741824;
          end
        end else begin
          cx_r <= 50'(job_r.x) <<< 16;
          cy_r <= 50'(job_r.y) <<< 16;
          az_r <= '0;
        end
      end
      ST_SQ: begin
        sum_r  <= sum_r + 66'(prod);
        sq_r   <= sq_r + 2'd1;
        rem_r  <= '0;
        root_r <= '0;
      end
      ST_RUN: begin
        if (step_r < StepW'(CordicSteps)) begin
          if (!cy_r[49]) begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            az_r <= az_r + 34'(atan_turn(step_r));
          end else begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            az_r <= az_r - 34'(atan_turn(step_r));
          end
        end
        sum_r <= {sum_r[63:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[32:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[32:0], 1'b0};
        end
        step_r <= step_r + 1'b1;
      end
      ST_DONE: begin
        if (!full_r || out_pop) begin
          res_r.out_x <= job_r.x;
          res_r.out_y <= job_r.y;
          res_r.out_z <= job_r.z;
          res_r.out_intensity <= job_r.ext ? {15'd0, job_r.inten[15]} : job_r.inten;
          res_r.out_distance  <= !job_r.ext ? 32'd0 :
                                 (root_c[32] ? 32'hffff_ffff : root_c[31:0]);
          if (!job_r.ext) begin
            res_r.out_azimuth <= '0;
          end else if (yzero_r) begin
            res_r.out_azimuth <= job_r.x[31] ? 16'sd32767 : 16'sd0;
          end else if (az_q > 18'sd32767) begin
            res_r.out_azimuth <= 16'sd32767;
          end else if (az_q < -18'sd32768) begin
            res_r.out_azimuth <= -16'sd32768;
          end else begin
            res_r.out_azimuth <= az_q[15:0];
          end
          res_r.out_channel   <= job_r.ext ? chan_r : 7'd0;
          res_r.out_elevation <= job_r.ext ? elev_r : 16'd0;
        end
      end
      default: ;
    endcase
  end
endmodule

/* rtl/lidar_point_polar_expander.sv */
// Lidar point polar expander top level: front, job queue, back.
// The back part works on one point at a time; in extended mode it runs the
// shared CORDIC and square-root step loop. Table words never enter the job
// queue, but like points they are refused while the queue is full.
// Reset (rst_n low, synchronous) empties the queues and the table count and
// clears extended_mode; table contents stay undefined until written.
`timescale 1ns / 1ps
module lidar_point_polar_expander (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                push,
  output logic                full,
  input  lppe_pkg::in_word_t  in_data,
  output logic                empty,
  input  logic                pop,
  output lppe_pkg::out_word_t out_data
);
  import lppe_pkg::*;

  logic                ext_r;
  logic                jpush, jfull, jpop, jempty;
  job_t                jin, jout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= 1'b0;
    end else if (cfg_we) begin
      ext_r <= cfg_wdata;
    end
  end

  lppe_front u_front (
    .clk(clk), .rst_n(rst_n), .ext_mode(ext_r),
    .in_push(push), .in_full(full), .in_data(in_data),
    .job_push(jpush), .job_full(jfull), .job(jin)
  );

  lppe_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(jpush), .full(jfull), .wdata(jin),
    .pop(jpop), .empty(jempty), .rdata(jout)
  );

  lppe_back u_back (
    .clk(clk), .rst_n(rst_n), .job_empty(jempty), .job_pop(jpop), .job(jout),
    .out_empty(empty), .out_pop(pop), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    jempty |-> !jpop) else $error("job popped from empty queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    jfull |-> full) else $error("input open while job queue full");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty) else $error("result word lost");
`endif
endmodule
